>>> rtl/core/sssc_pkg.sv
package sssc_pkg;

  // Input item of one (channel, time step, state element)
  typedef struct packed {
    logic [5:0]         channel;
    logic [3:0]         state_index;
    logic               last_state;
    logic               first_step;
    logic signed [15:0] x_value;
    logic [14:0]        delta;
    logic signed [15:0] a_value;
    logic signed [15:0] b_value;
    logic signed [15:0] c_value;
    logic signed [15:0] d_skip;
  } in_t;

  // Result item
  typedef struct packed {
    logic signed [31:0] y_value;
    logic [5:0]         out_channel;
  } out_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_EXP1,
    ST_EXP2,
    ST_DEC,
    ST_UPD,
    ST_ACC,
    ST_OUT
  } state_t;

  // Stage enables for the decay unit
  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } dec_ctl_t;

  localparam logic [16:0] E_ONE = 17'd65536;

  // exp(-j/16) in Q.16, j = 0..16
  function automatic logic [16:0] frac_exp(input logic [4:0] j);
    logic [16:0] v;
    unique case (j)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd61565;
      5'd2:    v = 17'd57835;
      5'd3:    v = 17'd54331;
      5'd4:    v = 17'd51039;
      5'd5:    v = 17'd47947;
      5'd6:    v = 17'd45042;
      5'd7:    v = 17'd42313;
      5'd8:    v = 17'd39750;
      5'd9:    v = 17'd37341;
      5'd10:   v = 17'd35079;
      5'd11:   v = 17'd32954;
      5'd12:   v = 17'd30957;
      5'd13:   v = 17'd29081;
      5'd14:   v = 17'd27319;
      5'd15:   v = 17'd25664;
      5'd16:   v = 17'd24109;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // exp(-k) in Q.16, k = 0..11
  function automatic logic [16:0] int_exp(input logic [3:0] k);
    logic [16:0] v;
    unique case (k)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd24109;
      4'd2:    v = 17'd8869;
      4'd3:    v = 17'd3263;
      4'd4:    v = 17'd1200;
      4'd5:    v = 17'd442;
      4'd6:    v = 17'd162;
      4'd7:    v = 17'd60;
      4'd8:    v = 17'd22;
      4'd9:    v = 17'd8;
      4'd10:   v = 17'd3;
      4'd11:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // Divide by 2^s, round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
    logic [63:0] half;
    logic [63:0] mag;
    half = 64'd1 << (s - 1);
    if (!v[63]) begin
      return $signed((64'(v) + half) >> s);
    end
    mag = (64'd0 - 64'(v) + half) >> s;
    return $signed(64'd0 - mag);
  endfunction

  // Saturate to the signed 32 bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

>>> rtl/core/sssc_decay.sv
module sssc_decay (
  input  logic                clk,
  input  sssc_pkg::dec_ctl_t  ctl,
  input  logic signed [31:0]  arg,
  output logic [16:0]         e_r
);
  import sssc_pkg::*;

  logic [31:0] m;
  logic [4:0]  j;
  logic [16:0] fj;
  logic [16:0] fj1;
  logic [16:0] diff;
  logic [36:0] prod;
  logic [16:0] g_nxt;
  logic [16:0] g_r;
  logic [3:0]  k_r;
  logic        pos_r;
  logic        big_r;
  logic [33:0] ep;
  logic [16:0] e_nxt;

  // Stage 1: interpolate the fractional part of the argument
  always_comb begin
    m     = 32'd0 - 32'(arg);
    j     = {1'b0, m[23:20]};
    fj    = frac_exp(j);
    fj1   = frac_exp(j + 5'd1);
    diff  = fj - fj1;
    prod  = 37'(diff) * 37'(m[19:0]);
    g_nxt = fj - 17'(prod >> 20);
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_en) begin
      g_r   <= g_nxt;
      k_r   <= m[27:24];
      pos_r <= !arg[31];
      big_r <= (m[31:24] >= 8'd12);
    end
  end

  // Stage 2: scale by the integer part
  always_comb begin
    ep = 34'(int_exp(k_r)) * 34'(g_r) + 34'd32768;
    priority if (pos_r) e_nxt = E_ONE;
    else if (big_r)     e_nxt = 17'd0;
    else                e_nxt = ep[32:16];
  end

  always_ff @(posedge clk) begin
    if (ctl.s2_en) begin
      e_r <= e_nxt;
    end
  end

endmodule

>>> rtl/core/selective_state_space_scan.sv
// Channel  | Direction | Handshake            | Payload
// in_      | input     | in_valid / in_stall  | in_data  (sssc_pkg::in_t)
// out_     | output    | out_valid / out_stall| out_data (sssc_pkg::out_t)
//
// An item runs through RD, EXP1, EXP2, DEC, UPD and ACC, and through OUT
// when it emits a result, before the next is taken; the hidden-state memory
// read, the decay table unit and the multiplies set that chain.
// After reset a clearing pass zeroes all CHANNELS*STATES memory entries,
// during which in_stall is high.
// A finished result waits in the output register while the next item runs.
module selective_state_space_scan #(
  parameter int CHANNELS = 64,
  parameter int STATES   = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  sssc_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output sssc_pkg::out_t  out_data
);
  import sssc_pkg::*;

  localparam int DEPTH = CHANNELS * STATES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t state_r;
  state_t state_nxt;

  in_t                item_r;
  logic [AW-1:0]      idx_r;
  logic [AW-1:0]      clr_r;
  logic               in_range;
  logic               accept;
  logic               clr_done;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_r;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_data;

  logic signed [31:0] arg_r;
  logic signed [31:0] pbx_r;
  logic signed [63:0] pbx2_r;
  logic signed [31:0] pd_r;
  logic signed [63:0] eh_r;
  logic signed [31:0] h_r;
  logic signed [31:0] h_nxt;
  logic signed [31:0] acc_r;
  logic signed [31:0] acc_nxt;
  logic signed [63:0] t;
  logic signed [31:0] hold;
  logic [16:0]        e_r;
  dec_ctl_t           dctl;

  logic               out_valid_r;
  out_t               out_r;
  logic               out_free;

  assign accept   = in_valid && !in_stall;
  assign in_range = (in_data.channel < CHANNELS) && (in_data.state_index < STATES);
  assign clr_done = (clr_r == AW'(DEPTH - 1));
  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_done) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid && in_range) state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_EXP1;
      ST_EXP1:  state_nxt = ST_EXP2;
      ST_EXP2:  state_nxt = ST_DEC;
      ST_DEC:   state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_ACC;
      ST_ACC:   state_nxt = item_r.last_state ? ST_OUT : ST_IDLE;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    dctl.s1_en = (state_r == ST_EXP1);
    dctl.s2_en = (state_r == ST_EXP2);
    wr_en      = (state_r == ST_CLEAR) || (state_r == ST_UPD);
    wr_addr    = (state_r == ST_CLEAR) ? clr_r : idx_r;
    wr_data    = (state_r == ST_CLEAR) ? 32'sd0 : h_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + AW'(1);
    end
  end

  // Hidden-state memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (state_r == ST_RD) rd_r <= mem[idx_r];
  end

  // Capture the item on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
      idx_r  <= AW'(int'(in_data.channel) * STATES + int'(in_data.state_index));
    end
  end

  sssc_decay u_decay (
    .clk (clk),
    .ctl (dctl),
    .arg (arg_r),
    .e_r (e_r)
  );

  assign hold = item_r.first_step ? 32'sd0 : rd_r;

  // Arithmetic datapath, the multiplies spread over the sequencer states
  always_comb begin
    h_nxt   = sat32(rnd(eh_r, 16) + rnd(pbx2_r, 20));
    t       = rnd(64'(h_r) * 64'(item_r.c_value), 12);
    acc_nxt = (item_r.state_index == 4'd0) ? sat32(t) : sat32(64'(acc_r) + t);
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_RD: begin
        arg_r <= $signed({17'd0, item_r.delta}) * 32'(item_r.a_value);
        pbx_r <= $signed({17'd0, item_r.delta}) * 32'(item_r.b_value);
        pd_r  <= 32'(item_r.d_skip) * 32'(item_r.x_value);
      end
      ST_EXP1: pbx2_r <= 64'(pbx_r) * 64'(item_r.x_value);
      ST_DEC:  eh_r   <= $signed({47'd0, e_r}) * 64'(hold);
      ST_UPD:  h_r    <= h_nxt;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (state_r == ST_ACC) begin
      acc_r <= acc_nxt;
    end
  end

  // Output register: load when free, drop valid once transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_r.y_value     <= sat32(64'(acc_r) + rnd(64'(pd_r), 8));
      out_r.out_channel <= item_r.channel;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A new result only follows the output step
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("result raised outside output step");

  // No transfer during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> in_stall)
    else $error("input taken during clearing pass");

  // Write-back is followed by the accumulate step
  a_upd_acc: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPD |=> state_r == ST_ACC)
    else $error("update not followed by accumulate");

endmodule
